### rtl/core/image_chunk_packet_framer_top_macros.svh
// assertion macros for the image chunk packet framer
// included by every rtl module that carries concurrent checks
`ifndef IMAGE_CHUNK_PACKET_FRAMER_TOP_MACROS_SVH
`define IMAGE_CHUNK_PACKET_FRAMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// check gated by reset
`define ICPF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds through reset
`define ICPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ICPF_ASSERT(lbl, clk, rst, prop, msg)
`define ICPF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/core/icpf_pkg.sv
// shared types and constants for the image chunk packet framer
// no dependencies; imported by icpf_div and the top level
package icpf_pkg;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // csr register indexes
   localparam logic CSR_CHUNK_MAX = 1'b0;
   localparam logic CSR_FRAME_MAX = 1'b1;

   // packet byte slots, in emission order
   localparam logic [2:0] SLOT_CMD0  = 3'd0;
   localparam logic [2:0] SLOT_CMD1  = 3'd1;
   localparam logic [2:0] SLOT_SEP0  = 3'd2;
   localparam logic [2:0] SLOT_FRAME = 3'd3;
   localparam logic [2:0] SLOT_DATA  = 3'd4;
   localparam logic [2:0] SLOT_SEP1  = 3'd5;
   localparam logic [2:0] SLOT_COUNT = 3'd6;

   // packet characters
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   // reset values of the csr registers
   localparam logic [7:0] CHUNK_MAX_RESET = 8'd235;
   localparam logic [7:0] FRAME_MAX_RESET = 8'd9;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### rtl/core/image_chunk_packet_framer_top.sv
// image chunk packet framer: wraps payload bytes into radio packets
// depends on icpf_pkg, icpf_div and image_chunk_packet_framer_top_macros.svh
//
//  channel  | direction | ports
//  ---------+-----------+------------------------------------------------------
//  req      | in        | req_valid/req_ready, req_mode, req_data_byte,
//           |           | req_frame_length
//  rsp      | out       | rsp_valid/rsp_ready, rsp_out_byte, rsp_packet_end,
//           |           | rsp_run_last
//  csr      | in        | csr_we, csr_index, csr_wdata (write only)
//
// one payload byte gives 1 to 7 packet bytes, one per cycle through the output register
// unless rsp stalls; in an item that closes a packet the count byte also waits for the
// serial divider, started at the transfer, to finish
// one item at a time: req_ready is high only while the sequencer is idle
// reset is synchronous; csr registers return to 235 and 9, no frame in progress
`include "image_chunk_packet_framer_top_macros.svh"

module image_chunk_packet_framer_top
   import icpf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic [12:0] req_frame_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_run_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int REM_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMP_W = (REM_W > 13) ? REM_W : 13;

   state_type        state_ff, state_in;
   logic [7:0]       chunk_max_ff, frame_max_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [7:0]       pos_ff, pos_in;
   logic [7:0]       frame_ff, frame_in;
   logic             mode_ff, mode_in;
   logic [7:0]       data_ff, data_in;
   logic [7:0]       hdr_frame_ff, hdr_frame_in;
   logic             close_ff, close_in;
   logic [2:0]       slot_ff, slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_end_ff, rsp_end_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             acc;
   logic [7:0]       csz;
   logic [CMP_W-1:0] len_ext;
   logic [REM_W-1:0] len_clamped;
   logic [REM_W-1:0] rem_start;
   logic [7:0]       pos_start;
   logic [7:0]       new_pos;
   logic [REM_W-1:0] new_rem;
   logic             close_now;
   logic [7:0]       frame_inc;
   logic             out_load;
   logic             slot_last;
   logic             div_start;
   div_stat_type     div_stat;
   logic [7:0]       div_q;

   // csr write port
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_max_ff <= CHUNK_MAX_RESET;
         frame_max_ff <= FRAME_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHUNK_MAX: chunk_max_ff <= csr_wdata;
            CSR_FRAME_MAX: frame_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item decode at the req transfer
   always_comb begin
      acc = req_valid && req_ready;
      csz = (chunk_max_ff == 8'd0) ? 8'd1 : chunk_max_ff;
      len_ext = CMP_W'(req_frame_length);
      if (len_ext == '0) begin
         len_clamped = REM_W'(1);
      end else if (len_ext > CMP_W'(MAX_FRAME_BYTES)) begin
         len_clamped = REM_W'(MAX_FRAME_BYTES);
      end else begin
         len_clamped = len_ext[REM_W-1:0];
      end
      if (rem_ff == '0) begin
         rem_start = len_clamped;
         pos_start = 8'd0;
      end else begin
         rem_start = rem_ff;
         pos_start = pos_ff;
      end
      new_pos   = pos_start + 8'd1;
      new_rem   = rem_start - REM_W'(1);
      close_now = (new_pos >= csz) || (new_pos == 8'd0) || (new_rem == '0);
      frame_inc = frame_ff + 8'd1;
      div_start = acc && close_now;
   end

   // serial divider for the packets-to-come byte
   icpf_div #(
      .DVD_W(REM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_rem),
      .divisor  (csz),
      .stat     (div_stat),
      .ceil_q   (div_q)
   );

   // sequencer: next state, frame bookkeeping and byte emission
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      frame_in     = frame_ff;
      mode_in      = mode_ff;
      data_in      = data_ff;
      hdr_frame_in = hdr_frame_ff;
      close_in     = close_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_last_in  = rsp_last_ff;
      req_ready    = 1'b0;
      out_load     = 1'b0;
      slot_last    = (slot_ff == SLOT_COUNT) || ((slot_ff == SLOT_DATA) && !close_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (acc) begin
               mode_in      = req_mode;
               data_in      = req_data_byte;
               hdr_frame_in = frame_ff;
               close_in     = close_now;
               slot_in      = (pos_start == 8'd0) ? SLOT_CMD0 : SLOT_DATA;
               rem_in       = new_rem;
               pos_in       = close_now ? 8'd0 : new_pos;
               if (close_now && (new_rem == '0)) begin
                  frame_in = (frame_inc > frame_max_ff) ? 8'd0 : frame_inc;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            out_load = (!rsp_valid_ff || rsp_ready)
                       && ((slot_ff != SLOT_COUNT) || div_stat.done);
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_end_in   = (slot_ff == SLOT_COUNT);
               rsp_last_in  = slot_last;
               case (slot_ff)
                  SLOT_CMD0:  rsp_byte_in = mode_ff ? CHAR_A : CHAR_I;
                  SLOT_CMD1:  rsp_byte_in = mode_ff ? CHAR_P : CHAR_X;
                  SLOT_SEP0:  rsp_byte_in = CHAR_COMMA;
                  SLOT_FRAME: rsp_byte_in = hdr_frame_ff;
                  SLOT_DATA:  rsp_byte_in = data_ff;
                  SLOT_SEP1:  rsp_byte_in = CHAR_COMMA;
                  SLOT_COUNT: rsp_byte_in = div_q;
                  default:    rsp_byte_in = data_ff;
               endcase
               slot_in = slot_ff + 3'd1;
               if (slot_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_ff       <= '0;
         pos_ff       <= 8'd0;
         frame_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         pos_ff       <= pos_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      data_ff      <= data_in;
      hdr_frame_ff <= hdr_frame_in;
      close_ff     <= close_in;
      slot_ff      <= slot_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_packet_end = rsp_end_ff;
   assign rsp_run_last   = rsp_last_ff;

   `ICPF_ASSERT(a_busy_after_transfer, clock, reset, acc |=> !req_ready, "ready after transfer")
   `ICPF_ASSERT(a_open_packet_in_frame, clock, reset, (pos_ff != 8'd0) |-> (rem_ff != '0), "open packet outside frame")
   `ICPF_ASSERT(a_count_needs_divider, clock, reset, (out_load && (slot_ff == SLOT_COUNT)) |-> div_stat.done, "count before divide")
   `ICPF_ASSERT(a_end_is_last, clock, reset, (rsp_valid_ff && rsp_end_ff) |-> rsp_last_ff, "packet end not last")

endmodule

### rtl/core/icpf_div.sv
// bit-serial restoring divider giving the low 8 bits of ceil(dividend / divisor)
// depends on icpf_pkg and image_chunk_packet_framer_top_macros.svh
`include "image_chunk_packet_framer_top_macros.svh"

module icpf_div
   import icpf_pkg::*;
#(
   parameter int DVD_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [7:0]       divisor,
   output div_stat_type     stat,
   output logic [7:0]       ceil_q
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       dvs_ff, dvs_in;

   logic [8:0]       trial;
   logic [8:0]       diff;
   logic             ge;
   logic [DVD_W+7:0] q_ext;

   // one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      ge    = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
         dvd_in  = dividend;
         rem_in  = 8'd0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[7:0] : trial[7:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // round up when the remainder is nonzero
   assign q_ext     = {8'd0, dvd_ff};
   assign ceil_q    = q_ext[7:0] + {7'd0, (rem_ff != 8'd0)};
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `ICPF_ASSERT(a_start_clears_done, clock, reset, start |=> !done_ff, "done after start")
   `ICPF_ASSERT(a_done_holds, clock, reset, (done_ff && !start) |=> done_ff, "done dropped")
   `ICPF_ASSERT(a_rem_below_divisor, clock, reset, done_ff |-> (rem_ff < dvs_ff), "bad remainder")
   `ICPF_ASSERT(a_not_both, clock, reset, !(busy_ff && done_ff), "busy and done")

endmodule
